// File: src/csi_pkg.sv
// shared types, field widths and codes for the sorted column insert block
package csi_pkg;

  // fixed field widths of the item and result beats
  localparam int unsigned ROW_W = 6;
  localparam int unsigned COL_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W = 10;
  localparam int unsigned CNT_W = 11;

  // configuration register file
  localparam int unsigned ROWS_W = 7;
  localparam int unsigned ROWS_RESET = 64;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_IDX_ROWS_IN_USE = 1'b0;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED = 2'd0,
    RES_PRESENT  = 2'd1,
    RES_FULL     = 2'd2,
    RES_BAD_ROW  = 2'd3
  } status_e;

  // controller states
  typedef enum logic [3:0] {
    CTL_IDLE,
    CTL_CHECK,
    CTL_LO,
    CTL_HI,
    CTL_PROBE,
    CTL_CMP,
    CTL_PLACE,
    CTL_SHIFT,
    CTL_DRAIN,
    CTL_KEY,
    CTL_INC,
    CTL_INC_DRAIN,
    CTL_RESULT
  } ctl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load_item;
    logic    tbl_rd_row;
    logic    cap_lo;
    logic    cap_hi;
    logic    probe;
    logic    compare;
    logic    place;
    logic    shift_step;
    logic    key_write;
    logic    inc_step;
    logic    inc_done;
    logic    set_result;
    status_e result_code;
    logic    load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic row_bad;
    logic seg_empty;
    logic probe_hit;
    logic store_full;
    logic no_shift;
    logic shift_last;
    logic inc_last;
    logic out_free;
  } sts_t;

endpackage

// File: src/csi_if.sv
// item and result channel interfaces

interface csi_item_if import csi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_number;
  logic [COL_W-1:0] column_index;

  modport source (output valid, output row_number, output column_index, input ready);
  modport sink (input valid, input row_number, input column_index, output ready);
endinterface

interface csi_result_if import csi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input position, input entry_count,
                output ready);
endinterface

// File: src/csi_ctrl.sv
// sequencer for search, shift and row offset update of one item
module csi_ctrl import csi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = CTL_CHECK;
        end
      end
      CTL_CHECK: begin
        if (sts_i.row_bad) begin
          cmd_o.set_result  = 1'b1;
          cmd_o.result_code = RES_BAD_ROW;
          state_d = CTL_RESULT;
        end else begin
          cmd_o.tbl_rd_row = 1'b1;
          state_d = CTL_LO;
        end
      end
      CTL_LO: begin
        cmd_o.cap_lo = 1'b1;
        state_d = CTL_HI;
      end
      CTL_HI: begin
        cmd_o.cap_hi = 1'b1;
        state_d = CTL_PROBE;
      end
      CTL_PROBE: begin
        if (sts_i.seg_empty) begin
          state_d = CTL_PLACE;
        end else begin
          cmd_o.probe = 1'b1;
          state_d = CTL_CMP;
        end
      end
      CTL_CMP: begin
        cmd_o.compare = 1'b1;
        if (sts_i.probe_hit) begin
          cmd_o.set_result  = 1'b1;
          cmd_o.result_code = RES_PRESENT;
          state_d = CTL_RESULT;
        end else begin
          state_d = CTL_PROBE;
        end
      end
      CTL_PLACE: begin
        if (sts_i.store_full) begin
          cmd_o.set_result  = 1'b1;
          cmd_o.result_code = RES_FULL;
          state_d = CTL_RESULT;
        end else begin
          cmd_o.place = 1'b1;
          state_d = sts_i.no_shift ? CTL_KEY : CTL_SHIFT;
        end
      end
      CTL_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_last) begin
          state_d = CTL_DRAIN;
        end
      end
      // last shifted entry lands this cycle
      CTL_DRAIN: begin
        state_d = CTL_KEY;
      end
      CTL_KEY: begin
        cmd_o.key_write = 1'b1;
        state_d = CTL_INC;
      end
      CTL_INC: begin
        cmd_o.inc_step = 1'b1;
        if (sts_i.inc_last) begin
          state_d = CTL_INC_DRAIN;
        end
      end
      CTL_INC_DRAIN: begin
        cmd_o.inc_done    = 1'b1;
        cmd_o.set_result  = 1'b1;
        cmd_o.result_code = RES_INSERTED;
        state_d = CTL_RESULT;
      end
      CTL_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

endmodule

// File: src/csi_datapath.sv
// column store, row start table, search registers and result register
module csi_datapath import csi_pkg::*; #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ROW_W-1:0]    row_number_i,
  input  logic [COL_W-1:0]    column_index_i,
  input  logic                cfg_we_i,
  input  logic [ROWS_W-1:0]   cfg_wdata_i,
  output logic [ROWS_W-1:0]   rows_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [POS_W-1:0]    out_position_o,
  output logic [CNT_W-1:0]    out_entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned TD = MAX_ROWS + 1;
  localparam int unsigned TW = $clog2(MAX_ROWS + 1);
  localparam int unsigned KW = (COLUMN_BITS < COL_W) ? COLUMN_BITS : COL_W;
  localparam int unsigned ROWS_CAP = (1 << ROWS_W) - 1;
  localparam int unsigned ROWS_LIM = (MAX_ROWS > ROWS_CAP) ? ROWS_CAP : MAX_ROWS;
  localparam int unsigned ROWS_RST = (ROWS_RESET > ROWS_LIM) ? ROWS_LIM : ROWS_RESET;
  localparam logic [ROWS_W-1:0] RowsLimit = ROWS_W'(ROWS_LIM);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // row count register value, zero acts as one, values above the limit clamp to it
  function automatic logic [ROWS_W-1:0] clamp_rows(logic [ROWS_W-1:0] v);
    logic [ROWS_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = ROWS_W'(1);
    end else if (v > RowsLimit) begin
      r = RowsLimit;
    end
    return r;
  endfunction

  logic [ROW_W-1:0]  row_q;
  logic [KW-1:0]     key_q;
  logic [CW-1:0]     lo_q, hi_q, mid_q, ptr_q, count_q, mid;
  logic [TW-1:0]     tptr_q, t_wa_q, row_tw, rows_tw, tbl_raddr;
  logic              t_wv_q, sh_wv_q;
  logic [AW-1:0]     sh_wa_q, store_raddr, store_waddr;
  logic [ROWS_W-1:0] rows_q;
  logic              store_we, probe_lt;
  logic [KW-1:0]     store_wdata;

  logic [KW-1:0]     store_mem [CAPACITY];
  logic [KW-1:0]     store_rdata_q;
  logic [CW-1:0]     tbl_mem [TD];
  logic [CW-1:0]     tbl_rdata_q, tbl_rd;
  logic              tbl_rvalid_q;
  logic [TD-1:0]     tbl_valid_q;

  status_e           res_status_q;
  logic [CW-1:0]     res_pos_q;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [CW-1:0]     out_pos_q, out_cnt_q;

  assign row_tw  = TW'(row_q);
  assign rows_tw = TW'(rows_q);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  // a row start never written since the last clear reads as zero
  assign tbl_rd  = tbl_rvalid_q ? tbl_rdata_q : '0;

  // row start table port selection
  always_comb begin
    tbl_raddr = row_tw;
    if (cmd_i.cap_lo) begin
      tbl_raddr = TW'(row_tw + TW'(1));
    end else if (cmd_i.inc_step) begin
      tbl_raddr = tptr_q;
    end
  end

  // row start table memory, pending increment written in the cycle after its read
  always_ff @(posedge clk_i) begin
    tbl_rdata_q <= tbl_mem[tbl_raddr];
    if (t_wv_q) begin
      tbl_mem[t_wa_q] <= tbl_rd + CW'(1);
    end
  end

  // column store port selection: shift moves entries up, key fills the hole
  assign store_raddr = cmd_i.shift_step ? AW'(ptr_q - CW'(1)) : AW'(mid);
  assign store_we    = sh_wv_q | cmd_i.key_write;
  assign store_waddr = sh_wv_q ? sh_wa_q : AW'(lo_q);
  assign store_wdata = sh_wv_q ? store_rdata_q : key_q;

  // column store memory
  always_ff @(posedge clk_i) begin
    store_rdata_q <= store_mem[store_raddr];
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
  end

  // control state: row count, entry count, valid bits, pending writes, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= ROWS_W'(ROWS_RST);
      count_q      <= '0;
      tbl_valid_q  <= '0;
      tbl_rvalid_q <= 1'b0;
      sh_wv_q      <= 1'b0;
      t_wv_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tbl_rvalid_q <= tbl_valid_q[tbl_raddr];
      sh_wv_q      <= cmd_i.shift_step;
      t_wv_q       <= cmd_i.inc_step;
      if (cfg_we_i) begin
        rows_q      <= clamp_rows(cfg_wdata_i);
        count_q     <= '0;
        tbl_valid_q <= '0;
      end else begin
        if (cmd_i.inc_done) begin
          count_q <= count_q + CW'(1);
        end
        if (t_wv_q) begin
          tbl_valid_q[t_wa_q] <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign probe_lt = store_rdata_q < key_q;

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      row_q <= row_number_i;
      key_q <= column_index_i[KW-1:0];
    end
    if (cmd_i.cap_lo) begin
      lo_q <= tbl_rd;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= tbl_rd;
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
    end
    // narrow the search window
    if (cmd_i.compare && !sts_o.probe_hit) begin
      if (probe_lt) begin
        lo_q <= mid_q + CW'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.place) begin
      ptr_q <= count_q;
    end
    if (cmd_i.shift_step) begin
      ptr_q   <= ptr_q - CW'(1);
      sh_wa_q <= AW'(ptr_q);
    end
    if (cmd_i.key_write) begin
      tptr_q <= TW'(row_tw + TW'(1));
    end
    if (cmd_i.inc_step) begin
      tptr_q <= TW'(tptr_q + TW'(1));
      t_wa_q <= tptr_q;
    end
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.result_code;
      case (cmd_i.result_code)
        RES_PRESENT:  res_pos_q <= mid_q;
        RES_INSERTED: res_pos_q <= lo_q;
        default:      res_pos_q <= '0;
      endcase
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_cnt_q    <= count_q;
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.row_bad    = ROWS_W'(row_q) >= rows_q;
    sts_o.seg_empty  = lo_q >= hi_q;
    sts_o.probe_hit  = store_rdata_q == key_q;
    sts_o.store_full = count_q >= CapCount;
    sts_o.no_shift   = count_q == lo_q;
    sts_o.shift_last = (ptr_q - CW'(1)) == lo_q;
    sts_o.inc_last   = tptr_q == rows_tw;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign rows_o            = rows_q;
  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_position_o    = POS_W'(out_pos_q);
  assign out_entry_count_o = CNT_W'(out_cnt_q);

  // the single store write port never sees a shift beat and the key together
  a_store_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sh_wv_q && cmd_i.key_write))
    else $error("column store write port collision");

  // entry count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("entry count beyond capacity");

  // an insertion completes only into a store that had room
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.inc_done |-> (count_q < CapCount))
    else $error("insertion into a full store");

  // every compare uses the store word read by the probe just before it
  a_probe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.compare |-> $past(cmd_i.probe))
    else $error("compare without preceding probe read");

endmodule

// File: src/csr_sorted_column_insert.sv
// top level of the sorted column index insert block for a CSR matrix structure
//
// Keeps a CSR pattern: a column store sorted within each row and a row start
// table. Each beat on item_i names a row and a column; one beat on result_o
// answers it with a status (inserted, already present, store full, row out of
// range), the store slot and the total entry count afterwards.
// One item is worked on at a time. The time from acceptance to result grows
// with the binary search depth over the row segment, the number of later
// entries shifted up one slot through the single-port column store, and the
// number of row starts above the row (rows_in_use - row_number) that the pass
// over the row start table updates. Rejected items (row out of range, full
// store, present column) finish without the shift and the row start pass.
// The result sits in an output register, so a new item is accepted while an
// earlier result waits for result_o.ready.
// Reset empties the matrix and sets rows_in_use to 64; writing rows_in_use
// over the APB port empties it too. No clearing pass is needed.
module csr_sorted_column_insert import csi_pkg::*; #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csi_item_if.sink              item_i,
  csi_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              cfg_we;
  logic [ROWS_W-1:0] rows;

  // apb register decode, writes land in the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_IDX_ROWS_IN_USE);
  assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_ROWS_IN_USE)
                ? {{(APB_DATA_W - ROWS_W){1'b0}}, rows} : '0;

  csi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csi_datapath #(
    .CAPACITY    (CAPACITY),
    .MAX_ROWS    (MAX_ROWS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .row_number_i      (item_i.row_number),
    .column_index_i    (item_i.column_index),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (pwdata[ROWS_W-1:0]),
    .rows_o            (rows),
    .out_ready_i       (result_o.ready),
    .out_valid_o       (result_o.valid),
    .out_status_o      (result_o.status),
    .out_position_o    (result_o.position),
    .out_entry_count_o (result_o.entry_count)
  );

endmodule

// File: bench/csr_pattern_checker.sv
// beat monitor, insert predictor and result comparison for the column insert block
module csr_pattern_checker import csi_pkg::*; #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csi_item_if                   item_bus,
  csi_result_if                 result_bus,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o
);

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
  } answer_t;

  // mirror of the csr pattern: sorted column store and row start offsets
  logic [COL_W-1:0] col_mem [CAPACITY];
  int unsigned      row_base [MAX_ROWS+1];
  int unsigned      row_limit;

  answer_t     pending_answers [$];
  answer_t     want;
  int unsigned mismatch_count;

  // register value as the block uses it: zero acts as one, above max clamps
  function automatic int unsigned clamp_rows(input logic [APB_DATA_W-1:0] value);
    int unsigned v;
    v = 32'(value[ROWS_W-1:0]);
    if (v < 1) return 1;
    if (v > MAX_ROWS) return MAX_ROWS;
    return v;
  endfunction

  // search the row segment, insert the column if absent and the store has room, and shift the rest up
  function automatic answer_t insert_column(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] key);
    answer_t     ans;
    int unsigned used, lo, hi, mid, j;
    bit          hit;
    used = row_base[row_limit];
    ans.status = RES_BAD_ROW;
    ans.position = '0;
    if (row < row_limit) begin
      lo = row_base[row];
      hi = row_base[row + 1];
      if (hi > used) hi = used;
      if (lo > hi) lo = hi;
      hit = 1'b0;
      while (lo < hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        if (col_mem[mid] < key) begin
          lo = mid + 1;
        end else if (col_mem[mid] == key) begin
          hit = 1'b1;
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      if (hit) begin
        ans.status = RES_PRESENT;
        ans.position = POS_W'(lo);
      end else if (used >= CAPACITY) begin
        ans.status = RES_FULL;
      end else begin
        for (j = used; j > lo; j--) col_mem[j] = col_mem[j - 1];
        col_mem[lo] = key;
        for (j = row + 1; j <= row_limit; j++) row_base[j]++;
        used++;
        ans.status = RES_INSERTED;
        ans.position = POS_W'(lo);
      end
    end
    ans.entry_count = CNT_W'(used);
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_answers.delete();
      foreach (row_base[k]) row_base[k] = 0;
      row_limit = clamp_rows(ROWS_RESET);
      mismatch_count = 0;
    end else begin
      // result beat against the oldest expectation
      if (result_bus.valid && result_bus.ready) begin
        if (pending_answers.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: status %0d position %0d count %0d",
                     result_bus.status, result_bus.position, result_bus.entry_count);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          if (result_bus.status != want.status || result_bus.position != want.position ||
              result_bus.entry_count != want.entry_count) begin
            if (mismatch_count < 10)
              $display("result mismatch (exp/got): status %0d/%0d position %0d/%0d count %0d/%0d",
                       want.status, result_bus.status, want.position, result_bus.position,
                       want.entry_count, result_bus.entry_count);
            mismatch_count++;
          end
        end
      end
      // item beat updates the mirror
      if (item_bus.valid && item_bus.ready)
        pending_answers.push_back(insert_column(item_bus.row_number, item_bus.column_index));
      // register write also empties the matrix
      if (psel && penable && pwrite && pready &&
          (paddr >> 2) == APB_ADDR_W'(REG_IDX_ROWS_IN_USE)) begin
        row_limit = clamp_rows(pwdata);
        foreach (row_base[k]) row_base[k] = 0;
      end
    end
    pending_o <= pending_answers.size();
    mismatches_o <= mismatch_count;
  end

endmodule

// File: bench/csr_sorted_column_insert_tb.sv
// stimulus, handshake pacing and verdict for the sorted column insert block
module csr_sorted_column_insert_tb;
  import csi_pkg::*;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned FILL_COUNT = 180;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           pending;
  int unsigned           mismatches;

  bit calm;
  bit hold_request;
  logic [COL_W-1:0] fill_cols [FILL_COUNT];

  csi_item_if   item_bus ();
  csi_result_if result_bus ();

  csr_sorted_column_insert #(
    .CAPACITY(CAPACITY),
    .MAX_ROWS(MAX_ROWS),
    .COLUMN_BITS(COL_W)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  csr_pattern_checker #(
    .CAPACITY(CAPACITY),
    .MAX_ROWS(MAX_ROWS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_bus    (item_bus),
    .result_bus  (result_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("csr_sorted_column_insert regression: fail");
    $finish;
  end

  // result side pacing, with one long hold on request
  initial begin
    bit held;
    held = 1'b0;
    result_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request && !held) begin
        held = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      result_bus.ready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  // one item beat; valid stays high afterwards until the next gap or drain
  task automatic send_beat(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    while (!calm && $urandom_range(0, 99) < 29) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.row_number <= row;
    item_bus.column_index <= col;
    do @(posedge clk_i); while (!item_bus.ready);
  endtask

  // stop offering and wait for every answer
  task automatic drain();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // apb write of rows_in_use, setup then access
  task automatic write_rows(input logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(REG_IDX_ROWS_IN_USE) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random beats: mostly valid rows, half the columns from a narrow range for repeats
  task automatic send_random(input int unsigned count, input int unsigned rows);
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    int unsigned      k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) row = ROW_W'($urandom_range(0, rows - 1));
      else row = ROW_W'($urandom_range(0, 63));
      if ($urandom_range(0, 1) != 0) col = COL_W'($urandom_range(0, 31));
      else col = COL_W'($urandom);
      send_beat(row, col);
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned k;
    rst_ni = 1'b0;
    calm = 1'b0;
    hold_request = 1'b0;
    item_bus.valid <= 1'b0;
    item_bus.row_number <= '0;
    item_bus.column_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting, 64 rows: field extremes, duplicates, mid-store inserts
    send_beat(6'd0, 16'h0000);
    send_beat(6'd0, 16'hFFFF);
    send_beat(6'd0, 16'h8000);
    send_beat(6'd0, 16'h0000);
    send_beat(6'd63, 16'hFFFF);
    send_beat(6'd63, 16'h0000);
    send_beat(6'd63, 16'hFFFF);
    send_beat(6'd31, 16'h5555);
    send_beat(6'd32, 16'hAAAA);
    send_beat(6'd0, 16'h0001);
    send_random(80, 64);
    drain();

    // register at its top code, clamps to 64; long receiver hold while items keep coming
    write_rows(32'd127);
    send_random(20, 64);
    hold_request = 1'b1;
    send_random(60, 64);
    drain();

    // single row: rows beyond it are answered as out of range
    write_rows(32'd1);
    send_beat(6'd0, 16'h0007);
    send_beat(6'd1, 16'h0007);
    send_beat(6'd63, 16'hFFFF);
    send_beat(6'd0, 16'h0007);
    send_beat(6'd0, 16'h0000);
    send_beat(6'd0, 16'hFFFF);
    send_random(30, 1);
    drain();

    // odd row count: a stretch with no idling, then a pause until all answers are in
    write_rows(32'd37);
    calm = 1'b1;
    send_random(50, 37);
    calm = 1'b0;
    drain();
    send_random(40, 37);
    drain();

    // zero acts as one row; grow a long ascending row, then hit it with repeats, new columns and rows beyond it
    write_rows(32'd0);
    for (k = 0; k < FILL_COUNT; k++) begin
      fill_cols[k] = COL_W'(k * 64 + $urandom_range(0, 63));
      send_beat(6'd0, fill_cols[k]);
    end
    for (k = 0; k < 24; k++) begin
      case (k % 3)
        0: send_beat(6'd0, fill_cols[$urandom_range(0, FILL_COUNT - 1)]);
        1: send_beat(6'd0, COL_W'($urandom));
        default: send_beat(ROW_W'($urandom_range(1, 63)), COL_W'($urandom));
      endcase
    end
    drain();

    // back to all rows
    write_rows(32'd64);
    send_random(40, 64);
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("csr_sorted_column_insert regression: pass");
    end else begin
      $display("csr_sorted_column_insert regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/csi_pkg.sv
src/csi_if.sv
src/csi_ctrl.sv
src/csi_datapath.sv
src/csr_sorted_column_insert.sv
bench/csr_pattern_checker.sv
bench/csr_sorted_column_insert_tb.sv
